### rtl/core/s2dec_pkg.sv
package s2dec_pkg;

  localparam int unsigned BCD_W = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic neg;
    logic last;
  } status_t;

endpackage

### rtl/core/s2dec_dp.sv
module s2dec_dp #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  s2dec_pkg::cmd_t       cmd_i,
  output s2dec_pkg::status_t    status_o,
  output logic [7:0]            char_code_o,
  output logic                  last_o
);

  localparam int unsigned BCD_BITS = s2dec_pkg::BCD_W * NDIG;
  localparam int unsigned CNT_W    = $clog2(DATA_WIDTH + 1);
  localparam int unsigned DIG_W    = $clog2(NDIG + 1);

  logic [DATA_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_BITS-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIG_W-1:0]      dig_q, dig_d;
  logic                  neg_q, neg_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic [BCD_BITS-1:0]   bcd_adj;
  logic [DATA_WIDTH-1:0] mag;
  logic [3:0]            top_digit;

  assign mag       = value_i[DATA_WIDTH-1] ? (~value_i + 1'b1) : value_i;
  assign top_digit = bcd_q[BCD_BITS-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(NDIG); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    dig_d  = dig_q;
    neg_d  = neg_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      bin_d = mag;
      bcd_d = '0;
      cnt_d = CNT_W'(DATA_WIDTH);
      dig_d = DIG_W'(NDIG);
      neg_d = value_i[DATA_WIDTH-1];
    end
    if (cmd_i.step) begin
      bcd_d = {bcd_adj[BCD_BITS-2:0], bin_q[DATA_WIDTH-1]};
      bin_d = {bin_q[DATA_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.skip) begin
      bcd_d = {bcd_q[BCD_BITS-5:0], 4'b0000};
      dig_d = dig_q - 1'b1;
    end
    if (cmd_i.put_sign) begin
      char_d = s2dec_pkg::ASCII_MINUS;
      last_d = 1'b0;
    end
    if (cmd_i.put_digit) begin
      char_d = s2dec_pkg::ASCII_ZERO + {4'b0000, top_digit};
      last_d = (dig_q == DIG_W'(1));
      bcd_d  = {bcd_q[BCD_BITS-5:0], 4'b0000};
      dig_d  = dig_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dig_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      dig_q <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.conv_done = (cnt_q == CNT_W'(1));
  assign status_o.lead_zero = (top_digit == 4'd0) && (dig_q > DIG_W'(1));
  assign status_o.neg       = neg_q;
  assign status_o.last      = last_q;

  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

### rtl/core/s2dec_ctrl.sv
module s2dec_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  s2dec_pkg::status_t status_i,
  output s2dec_pkg::cmd_t    cmd_o
);

  s2dec_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      s2dec_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = s2dec_pkg::ST_CONV;
      end
      s2dec_pkg::ST_CONV: begin
        if (status_i.conv_done) state_d = s2dec_pkg::ST_SKIP;
      end
      s2dec_pkg::ST_SKIP: begin
        if (!status_i.lead_zero) state_d = s2dec_pkg::ST_OUT;
      end
      s2dec_pkg::ST_OUT: begin
        if (out_ready_i && status_i.last) state_d = s2dec_pkg::ST_IDLE;
      end
      default: state_d = s2dec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      s2dec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      s2dec_pkg::ST_CONV: begin
        cmd_o.step = 1'b1;
      end
      s2dec_pkg::ST_SKIP: begin
        // drop leading zeros, then load the first character
        if (status_i.lead_zero) begin
          cmd_o.skip = 1'b1;
        end else if (status_i.neg) begin
          cmd_o.put_sign = 1'b1;
        end else begin
          cmd_o.put_digit = 1'b1;
        end
      end
      s2dec_pkg::ST_OUT: begin
        out_valid_o     = 1'b1;
        cmd_o.put_digit = out_ready_i && !status_i.last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= s2dec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/signed_int_to_decimal_ascii_top.sv
// Channel   Direction  tdata                                tlast
// s_axis    in         [DATA_WIDTH-1:0] value (signed)       -
// m_axis    out        [7:0] char_code                      last character of the number
//
// A number goes through one accept step, DATA_WIDTH double-dabble shift steps,
// Z skipped leading zero digits (up to NDIG-1), a step to load the first
// character, then C characters (1 to NDIG+1) at one per cycle while m_axis is
// ready. Z + C is NDIG plus one for a sign.
// Reset clears the controller and counters; a stalled m_axis holds the character.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [DATA_WIDTH-1:0] value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] char_code
  output logic                            m_axis_tlast   // last
);

  // decimal digits of 2**(DATA_WIDTH-1)
  localparam int unsigned NDIG = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;

  s2dec_pkg::cmd_t    cmd;
  s2dec_pkg::status_t status;

  s2dec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  s2dec_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .NDIG       (NDIG)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_code_o (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

### rtl/core/s2dec_chk.sv
module s2dec_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled character changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready again right after a request");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("new request taken while characters pending");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == s2dec_pkg::ASCII_MINUS && !m_axis_tlast) ||
      (m_axis_tdata >= s2dec_pkg::ASCII_ZERO &&
       m_axis_tdata <= s2dec_pkg::ASCII_ZERO + 8'd9))
    else $error("character outside sign and digits");

  a_end_of_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("characters continue past the last one");

endmodule

bind signed_int_to_decimal_ascii_top s2dec_chk u_s2dec_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/tb_signed_int_to_decimal_ascii_top.sv
module tb_signed_int_to_decimal_ascii_top;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned RADIX      = 10;
  localparam int unsigned MAX_GAP    = 7;
  localparam int unsigned TAIL_WAIT  = 80;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // [DATA_WIDTH-1:0] value
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;   // [7:0] char_code
  logic               m_axis_tlast;   // last

  char_t       text_due[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold;

  signed_int_to_decimal_ascii_top #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Expected text of one number: optional minus, then digits, last flag on the final digit.
  function automatic void render_decimal(input logic [DATA_WIDTH-1:0] value);
    logic [DATA_WIDTH-1:0] mag;
    logic [7:0]            digit[$];
    char_t                 c;
    mag = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
    do begin
      digit.push_front(s2dec_pkg::ASCII_ZERO + 8'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (value[DATA_WIDTH-1]) begin
      c.code = s2dec_pkg::ASCII_MINUS;
      c.last = 1'b0;
      text_due.push_back(c);
    end
    foreach (digit[i]) begin
      c.code = digit[i];
      c.last = (i == digit.size() - 1);
      text_due.push_back(c);
    end
  endfunction

  // Offer one request; the caller owns tvalid afterwards and must lower it before waiting.
  task automatic send_value(input logic [DATA_WIDTH-1:0] value);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    render_decimal(value);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (text_due.size() != 0) @(posedge clk_i);
  endtask

  // Mixed magnitudes so every digit count and both signs show up often.
  function automatic logic [DATA_WIDTH-1:0] draw_value();
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     nd;
    logic [DATA_WIDTH-1:0] mag;
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return ($urandom_range(1, 0) != 0) ? MOST_NEG : MOST_POS;
      default: begin
        nd = $urandom_range(10, 1);
        lo = (nd == 1) ? 0 : 64'd10 ** (nd - 1);
        hi = 64'd10 ** nd - 1;
        if (hi > MOST_POS) hi = MOST_POS;
        mag = DATA_WIDTH'(lo + ($urandom() % (hi - lo + 1)));
        return ($urandom_range(1, 0) != 0) ? (~mag + 1'b1) : mag;
      end
    endcase
  endfunction

  initial begin
    rx_hold = 0;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else if (rx_idle_on && $urandom_range(MAX_GAP, 0) != 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && rx_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (text_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected char: got code %0d last %0b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = text_due.pop_front();
        if (m_axis_tdata !== want.code || m_axis_tlast !== want.last) begin
          if (mismatches < 10)
            $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                     want.code, want.last, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [DATA_WIDTH-1:0] corner[$];
    corner = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 123456789, -987654321,
               1000000000, -1000000000, 1999999999, 32'h5555_5555, 32'hAAAA_AAAA,
               MOST_POS, MOST_NEG, MOST_NEG + 1};
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (corner[i]) send_value(corner[i]);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(input bit tx_idle, input bit rx_idle, input int unsigned count);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    repeat (count) send_value(draw_value());
    stop_sending();
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // hold the output long enough that the input stalls behind the first number
    rx_hold = LONG_HOLD;
    repeat (6) send_value(draw_value());
    stop_sending();
    wait_drained();
    // sender pauses with nothing outstanding, then resumes
    rx_idle_on = 1'b1;
    repeat (3) send_value(draw_value());
    stop_sending();
    wait_drained();
    repeat (3) send_value(MOST_NEG);
    stop_sending();
    wait_drained();
  endtask

  initial begin
    mismatches = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(1'b1, 1'b1, 50);
    test_random(1'b0, 1'b0, 50);
    test_random(1'b1, 1'b0, 50);
    test_random(1'b0, 1'b1, 50);
    test_backpressure();

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && text_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
